// ===== rtl/bounded_priority_queue_assert.svh =====
// Assertion macros for the bounded priority queue.
// Used by the top level only; depends on a clock named clock and a reset named reset.
`ifndef BOUNDED_PRIORITY_QUEUE_ASSERT_SVH
`define BOUNDED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BPQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define BPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bpq_pkg.sv =====
// Shared types and codes for the bounded priority queue.
// No dependencies; imported by bpq_cell, bounded_priority_queue, the checker and the testbench.
package bpq_pkg;

   // Request command codes
   typedef enum logic [1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_FILTER  = 2'd2
   } cmd_type;

   // Response status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // What every cell does in a cycle
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_POP
   } cell_op_type;

   // Controller states
   typedef enum logic {
      S_IDLE,
      S_FILTER
   } state_type;

   // One queue entry
   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] prio;
   } entry_type;

   // Broadcast control from the controller to the cell row
   typedef struct packed {
      cell_op_type op;
      entry_type   item;
   } cell_ctrl_type;

endpackage

// ===== rtl/bpq_cell.sv =====
// One slot of the sorted cell row: holds an entry, shifts right on insert, left on pop.
// Depends on bpq_pkg.
module bpq_cell #(
   parameter int DEPTH = 64,
   parameter int INDEX = 0,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                   clock,
   input  bpq_pkg::cell_ctrl_type ctrl,
   input  logic [CW-1:0]          count,
   input  bpq_pkg::entry_type     left_entry,
   input  logic                   left_stay,
   input  bpq_pkg::entry_type     right_entry,
   output bpq_pkg::entry_type     entry,
   output logic                   stay
);
   import bpq_pkg::*;

   localparam logic [CW-1:0] IDX = CW'(INDEX);

   entry_type entry_ff;
   entry_type entry_in;
   logic      occupied;

   // A slot keeps its entry on insert when it holds one of at least the new priority
   assign occupied = (count > IDX);
   assign stay     = occupied && (entry_ff.prio >= ctrl.item.prio);
   assign entry    = entry_ff;

   // Next entry: hold, take the new item, or take a neighbor's
   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.op)
         OP_HOLD: begin
            entry_in = entry_ff;
         end
         OP_INSERT: begin
            if (stay) begin
               entry_in = entry_ff;
            end else if (left_stay) begin
               entry_in = ctrl.item;
            end else begin
               entry_in = left_entry;
            end
         end
         OP_POP: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/bounded_priority_queue.sv =====
// Bounded priority queue: top level with controller and the row of bpq_cell slots.
// Depends on bpq_pkg, bpq_cell and bounded_priority_queue_assert.svh.
//
// Entries sit in a row of cells, highest priority at cell 0, equal priorities in
// arrival order. Enqueue and dequeue may be issued every cycle; busy stays low
// for them. A filter holds busy until no entry above its limit is left: since
// the row is sorted, the removed entries are a prefix, and the row pops one of
// them a cycle. The response comes in the cycle after the command completes,
// for one cycle on rsp_valid; the receiver cannot stall it, so it must take every
// response as it appears.
`include "bounded_priority_queue_assert.svh"

module bounded_priority_queue #(
   parameter int DEPTH = 64,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_item_value,
   input  logic signed [31:0] req_item_priority,
   input  logic signed [31:0] req_limit,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_out_value,
   output logic               rsp_out_valid,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_occupancy
);
   import bpq_pkg::*;

   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_COUNT  = CW'(1);

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic signed [31:0] limit_ff, limit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic               rsp_ok_ff, rsp_ok_in;
   status_type         rsp_status_ff, rsp_status_in;

   cell_ctrl_type      ctrl;
   entry_type          cell_entry [DEPTH];
   logic               cell_stay  [DEPTH];
   logic               accept;

   assign busy   = (state_ff == S_FILTER);
   assign accept = start && !busy;

   // Cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_e, right_e;
      logic      left_s;
      if (i == 0) begin : g_first
         assign left_e = ctrl.item;
         assign left_s = 1'b1;
      end else begin : g_mid
         assign left_e = cell_entry[i-1];
         assign left_s = cell_stay[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_e = cell_entry[i];
      end else begin : g_inner
         assign right_e = cell_entry[i+1];
      end
      bpq_cell #(.DEPTH(DEPTH), .INDEX(i)) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count       (count_ff),
         .left_entry  (left_e),
         .left_stay   (left_s),
         .right_entry (right_e),
         .entry       (cell_entry[i]),
         .stay        (cell_stay[i])
      );
   end

   // Controller: next state, cell command and response
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      limit_in      = limit_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_status_in = rsp_status_ff;
      ctrl.op       = OP_HOLD;
      ctrl.item     = '{value: req_item_value, prio: req_item_priority};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_value_in  = '0;
               rsp_ok_in     = 1'b0;
               rsp_status_in = ST_OK;
               case (req_command)
                  CMD_ENQUEUE: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= FULL_COUNT) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ctrl.op  = OP_INSERT;
                        count_in = count_ff + ONE_COUNT;
                     end
                  end
                  CMD_DEQUEUE: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        ctrl.op      = OP_POP;
                        count_in     = count_ff - ONE_COUNT;
                        rsp_value_in = cell_entry[0].value;
                        rsp_ok_in    = 1'b1;
                     end
                  end
                  CMD_FILTER: begin
                     limit_in = req_limit;
                     state_in = S_FILTER;
                  end
                  default: begin
                     // unused command: report occupancy only
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_FILTER: begin
            // drop the front while it lies above the limit
            if ((count_ff != '0) && (cell_entry[0].prio > limit_ff)) begin
               ctrl.op  = OP_POP;
               count_in = count_ff - ONE_COUNT;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      limit_ff      <= limit_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_valid = rsp_ok_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = 7'(count_ff);

   // Checks
   `BPQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= FULL_COUNT, "count above depth")
   `BPQ_ASSERT_NOW(a_out_valid_ok, rsp_valid && rsp_out_valid, rsp_status == ST_OK, "value with bad status")
   `BPQ_ASSERT_NEXT(a_deq_result, accept && (req_command == CMD_DEQUEUE) && (count_ff != '0), rsp_valid && rsp_out_valid && (count_ff == $past(count_ff) - ONE_COUNT), "dequeue result missing")
   `BPQ_ASSERT_NEXT(a_filter_shrinks, state_ff == S_FILTER, count_ff <= $past(count_ff), "filter grew queue")

endmodule

// ===== dv/bounded_priority_queue_checker.sv =====
// Response checker for the bounded priority queue: watches the command and response
// channels, keeps its own sorted copy of the queue and compares every response.
// Depends on bpq_pkg for the command and status codes.
`timescale 1ns / 1ps

module bounded_priority_queue_checker #(
   parameter int DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_item_value,
   input  logic signed [31:0] req_item_priority,
   input  logic signed [31:0] req_limit,
   input  logic               rsp_valid,
   input  logic signed [31:0] rsp_out_value,
   input  logic               rsp_out_valid,
   input  logic [1:0]         rsp_status,
   input  logic [6:0]         rsp_occupancy,
   output int                 mismatch_count,
   output int                 responses_owed
);
   import bpq_pkg::*;

   typedef struct {
      logic signed [31:0] val;
      logic signed [31:0] prio;
   } slot_type;

   typedef struct {
      logic signed [31:0] value;
      logic               valid;
      status_type         status;
      logic [6:0]         occupancy;
   } outcome_type;

   slot_type    queue_model[$];
   outcome_type owed_outcomes[$];

   initial begin
      mismatch_count = 0;
      responses_owed = 0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Apply one command to the model queue and return the response it should give
   function automatic outcome_type apply_command(input logic [1:0] cmd,
                                                 input logic signed [31:0] val,
                                                 input logic signed [31:0] prio,
                                                 input logic signed [31:0] lim);
      outcome_type res;
      slot_type    item;
      slot_type    kept[$];
      int          pos;
      res.value = '0;
      res.valid = 1'b0;
      res.status = ST_OK;
      case (cmd)
         CMD_ENQUEUE: begin
            if (queue_model.size() >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               // new pair goes behind every entry of equal or higher priority
               pos = 0;
               while (pos < queue_model.size() && queue_model[pos].prio >= prio) pos++;
               item.val = val;
               item.prio = prio;
               queue_model.insert(pos, item);
            end
         end
         CMD_DEQUEUE: begin
            if (queue_model.size() == 0) begin
               res.status = ST_EMPTY;
            end else begin
               item = queue_model.pop_front();
               res.value = item.val;
               res.valid = 1'b1;
            end
         end
         CMD_FILTER: begin
            foreach (queue_model[i]) begin
               if (queue_model[i].prio <= lim) kept.push_back(queue_model[i]);
            end
            queue_model = kept;
         end
         default: ;  // unused code: no operation
      endcase
      res.occupancy = 7'(queue_model.size());
      return res;
   endfunction

   // Responses are checked before the transfer of the same edge is predicted
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         queue_model.delete();
         owed_outcomes.delete();
      end else begin
         if (rsp_valid) begin
            if (owed_outcomes.size() == 0) begin
               report_mismatch("response with no command outstanding");
            end else begin
               want = owed_outcomes.pop_front();
               if (rsp_out_value !== want.value)
                  report_mismatch($sformatf("out_value got %0d want %0d",
                                            rsp_out_value, want.value));
               if (rsp_out_valid !== want.valid)
                  report_mismatch($sformatf("out_valid got %b want %b",
                                            rsp_out_valid, want.valid));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_status, want.status));
               if (rsp_occupancy !== want.occupancy)
                  report_mismatch($sformatf("occupancy got %0d want %0d",
                                            rsp_occupancy, want.occupancy));
            end
         end
         if (start && !busy)
            owed_outcomes.push_back(apply_command(req_command, req_item_value,
                                                  req_item_priority, req_limit));
      end
      responses_owed = owed_outcomes.size();
   end

endmodule

// ===== dv/bounded_priority_queue_tb.sv =====
// Testbench top for the bounded priority queue: clock, reset, command stimulus and verdict.
// Depends on bpq_pkg, the bounded_priority_queue RTL and bounded_priority_queue_checker.
`timescale 1ns / 1ps

module bounded_priority_queue_tb;
   import bpq_pkg::*;

   localparam int         DEPTH       = 64;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         RANDOM_CMDS = 1300;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   typedef enum {FILL_UP, DRAIN_DOWN, BALANCED} traffic_mix_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_command;
   logic signed [31:0] req_item_value;
   logic signed [31:0] req_item_priority;
   logic signed [31:0] req_limit;
   logic               rsp_valid;
   logic signed [31:0] rsp_out_value;
   logic               rsp_out_valid;
   logic [1:0]         rsp_status;
   logic [6:0]         rsp_occupancy;
   int                 mismatch_count;
   int                 responses_owed;
   int                 cycle_count;
   bit                 idle_enable;

   bounded_priority_queue #(.DEPTH(DEPTH)) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .req_limit         (req_limit),
      .rsp_valid         (rsp_valid),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy)
   );

   bounded_priority_queue_checker #(.DEPTH(DEPTH)) i_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .req_limit         (req_limit),
      .rsp_valid         (rsp_valid),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy),
      .mismatch_count    (mismatch_count),
      .responses_owed    (responses_owed)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // One command transfer: optional idle cycles, then hold start until accepted
   task automatic issue_command(input logic [1:0] cmd, input logic signed [31:0] val,
                                input logic signed [31:0] prio,
                                input logic signed [31:0] lim);
      while (idle_enable && $urandom_range(99) < 24) begin
         @(negedge clock);
         start <= 1'b0;
         req_command <= 2'($urandom);
         req_item_value <= $urandom;
         req_item_priority <= $urandom;
         req_limit <= $urandom;
      end
      @(negedge clock);
      start <= 1'b1;
      req_command <= cmd;
      req_item_value <= val;
      req_item_priority <= prio;
      req_limit <= lim;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Narrow priorities collide often, which exercises arrival order among equals
   function automatic logic signed [31:0] pick_priority(input bit narrow);
      if (narrow) return $signed(32'($urandom_range(8))) - 32'sd4;
      return $urandom;
   endfunction

   function automatic logic signed [31:0] pick_limit(input bit narrow);
      case ($urandom_range(9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         default: return pick_priority(narrow);
      endcase
   endfunction

   function automatic logic [1:0] pick_command(input traffic_mix_type mix);
      int r;
      int enq_pct;
      int deq_pct;
      r = $urandom_range(99);
      case (mix)
         FILL_UP:    begin enq_pct = 80; deq_pct = 94; end
         DRAIN_DOWN: begin enq_pct = 15; deq_pct = 92; end
         default:    begin enq_pct = 48; deq_pct = 92; end
      endcase
      if (r < enq_pct) return CMD_ENQUEUE;
      if (r < deq_pct) return CMD_DEQUEUE;
      if (r < 98) return CMD_FILTER;
      return CMD_UNUSED;
   endfunction

   initial begin
      traffic_mix_type mix;
      bit              narrow;
      int              sent;
      int              phase_len;
      int              phase_idx;
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_ENQUEUE;
      req_item_value = '0;
      req_item_priority = '0;
      req_limit = '0;
      idle_enable = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty cases, extremes, ties, unused code, filter edges
      issue_command(CMD_DEQUEUE, 32'sd99, 32'sd0, 32'sd0);         // empty dequeue
      issue_command(CMD_FILTER, 32'sd0, 32'sd0, 32'sh7fffffff);    // filter on empty
      issue_command(CMD_UNUSED, 32'sd5, 32'sd5, 32'sd5);
      issue_command(CMD_ENQUEUE, 32'sh7fffffff, 32'sh80000000, 32'sd0);
      issue_command(CMD_ENQUEUE, 32'sh80000000, 32'sh7fffffff, 32'sd0);
      issue_command(CMD_ENQUEUE, 32'sd1, 32'sd0, 32'sd0);
      issue_command(CMD_ENQUEUE, 32'sd2, 32'sd0, 32'sd0);
      issue_command(CMD_ENQUEUE, 32'sd3, 32'sd0, 32'sd0);
      issue_command(CMD_ENQUEUE, -32'sd1, -32'sd1, 32'sd0);
      issue_command(CMD_ENQUEUE, 32'sd0, 32'sh7fffffff, 32'sd0);    // tie at the top
      issue_command(CMD_UNUSED, 32'sd0, 32'sd0, 32'sh80000000);
      issue_command(CMD_DEQUEUE, 32'sd0, 32'sd0, 32'sd0);
      issue_command(CMD_ENQUEUE, 32'sd77, 32'sd5, 32'sd0);
      issue_command(CMD_FILTER, 32'sd0, 32'sd0, 32'sd0);            // removes a prefix
      issue_command(CMD_FILTER, 32'sd0, 32'sd0, 32'sh7fffffff);     // removes nothing
      issue_command(CMD_DEQUEUE, 32'sd0, 32'sd0, 32'sd0);
      issue_command(CMD_ENQUEUE, 32'sd4, 32'sh80000000, 32'sd0);
      issue_command(CMD_FILTER, 32'sd0, 32'sd0, 32'sh80000000);     // keeps only the minimum
      issue_command(CMD_DEQUEUE, 32'sd0, 32'sd0, 32'sd0);
      issue_command(CMD_DEQUEUE, 32'sd0, 32'sd0, 32'sd0);
      issue_command(CMD_DEQUEUE, 32'sd0, 32'sd0, 32'sd0);            // empty again

      // Random phases; the first fills the queue, one stretch runs without idling
      sent = 0;
      phase_idx = 0;
      while (sent < RANDOM_CMDS) begin
         mix = (phase_idx == 0) ? FILL_UP : traffic_mix_type'($urandom_range(2));
         narrow = $urandom_range(1);
         idle_enable = (phase_idx != 4);
         phase_len = $urandom_range(60, 130);
         repeat (phase_len) begin
            issue_command(pick_command(mix), $urandom, pick_priority(narrow),
                          pick_limit(narrow));
            sent++;
         end
         phase_idx++;
      end

      @(negedge clock);
      start <= 1'b0;
      while (responses_owed != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
